>>> hdl/perspective_project_to_viewport_macros.svh
// Assertion macros shared by the projection block.
`ifndef PERSPECTIVE_PROJECT_TO_VIEWPORT_MACROS_SVH
`define PERSPECTIVE_PROJECT_TO_VIEWPORT_MACROS_SVH

// implication checked every clock outside reset
`define PPV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked in the cycle after the antecedent, reset included
`define PPV_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ppv_pkg.sv
// Shared constants, register codes and types of the projection block.
`timescale 1ns / 1ps
package ppv_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_AW        = 3;
   localparam int QUO_BITS      = 41;
   localparam int FIFO_DEPTH    = 4;

   typedef enum logic [CSR_AW-1:0] {
      REG_XROW_LO = 3'd0,
      REG_XROW_HI = 3'd1,
      REG_YROW_LO = 3'd2,
      REG_YROW_HI = 3'd3,
      REG_WROW_LO = 3'd4,
      REG_WROW_HI = 3'd5,
      REG_VP_HORIZ = 3'd6,
      REG_VP_VERT  = 3'd7
   } reg_index_type;

   localparam logic [63:0] XROW_LO_RST = 64'h0000_0000_0001_0000;
   localparam logic [63:0] YROW_LO_RST = 64'h0001_0000_0000_0000;
   localparam logic [63:0] WROW_HI_RST = 64'h0001_0000_0000_0000;

   typedef struct packed {
      logic [63:0] xrow_lo;
      logic [63:0] xrow_hi;
      logic [63:0] yrow_lo;
      logic [63:0] yrow_hi;
      logic [63:0] wrow_lo;
      logic [63:0] wrow_hi;
      logic [63:0] viewport_horiz;
      logic [63:0] viewport_vert;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

>>> hdl/perspective_project_to_viewport.sv
// Top level of the perspective projection and viewport mapping block.
//
// Input words arrive on req_*: one 3D point in signed Q16.16, one per
// word. Result words leave on rsp_*: the saturated screen position plus
// a zero-w flag and an overflow flag, one result for every point, in order.
// The csr_* port writes the three matrix rows and the viewport edges; write
// it only while no point is in flight.
// An accepted point passes these stages in order: the accepting edge loads
// the first of two front stages for the dot products, then come one queue
// slot, three mapping stages, a divider load stage, 41 restoring divider
// stages of one quotient bit each, and the output register.
// Throughput is one point per cycle while rsp_tready is not held low;
// every stage of the divider works on a different point.
// When the receiver holds rsp_tready low the back pipeline holds; the front
// keeps taking points until the four-entry queue fills, then req_tready
// drops. Synchronous reset empties all pipelines and the queue and reloads
// the identity rows and a zero viewport.
`timescale 1ns / 1ps
`include "perspective_project_to_viewport_macros.svh"
module perspective_project_to_viewport #(
   parameter int FRAC_BITS = ppv_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [95:0]                 req_tdata,  // point_x, point_y, point_z
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata,  // screen_x, screen_y
   output logic [1:0]                  rsp_tuser,  // w_zero, overflowed
   input  logic                        csr_wen,
   input  logic [ppv_pkg::CSR_AW-1:0]  csr_waddr,
   input  logic [63:0]                 csr_wdata
);
   import ppv_pkg::*;

   localparam int ITEM_W = 3 * (66 - FRAC_BITS) + 1;

   cfg_type          cfg_ff;
   logic             q_push, q_pop;
   logic [ITEM_W-1:0] q_wdata, q_rdata;
   fifo_stat_type    q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{xrow_lo: XROW_LO_RST, yrow_lo: YROW_LO_RST,
                     wrow_hi: WROW_HI_RST, default: '0};
      end else if (csr_wen) begin
         case (csr_waddr)
            REG_XROW_LO:  cfg_ff.xrow_lo        <= csr_wdata;
            REG_XROW_HI:  cfg_ff.xrow_hi        <= csr_wdata;
            REG_YROW_LO:  cfg_ff.yrow_lo        <= csr_wdata;
            REG_YROW_HI:  cfg_ff.yrow_hi        <= csr_wdata;
            REG_WROW_LO:  cfg_ff.wrow_lo        <= csr_wdata;
            REG_WROW_HI:  cfg_ff.wrow_hi        <= csr_wdata;
            REG_VP_HORIZ: cfg_ff.viewport_horiz <= csr_wdata;
            REG_VP_VERT:  cfg_ff.viewport_vert  <= csr_wdata;
            default:      cfg_ff                <= cfg_ff;
         endcase
      end
   end

   ppv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_stat.full),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   ppv_fifo #(.WIDTH(ITEM_W), .DEPTH(FIFO_DEPTH)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   ppv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_data     (q_rdata),
      .q_empty    (q_stat.empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `PPV_ASSERT_NOW(a_wzero_clean, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0 && !rsp_tuser[1], "zero w word carries data")
   `PPV_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid && q_stat.empty, "pipeline not empty after reset")
   `PPV_ASSERT_NOW(a_queue_flags, clock, reset, q_stat.full, !q_stat.empty && !q_push, "queue written while full")

endmodule

>>> hdl/ppv_front.sv
// Front end: accepts points and forms clip x, y and w.
`timescale 1ns / 1ps
module ppv_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ppv_pkg::cfg_type               cfg,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [95:0]                    req_tdata,
   input  logic                           q_full,
   output logic                           q_push,
   output logic [3*(66-FRAC_BITS):0]      q_data
);
   import ppv_pkg::*;

   localparam int CW = 66 - FRAC_BITS;

   logic               v1_ff, v2_ff, en;
   logic signed [63:0] prod_ff [3][3];
   logic signed [31:0] cst_ff [3];
   logic [CW-1:0]      clip_ff [3];
   logic [CW-1:0]      clip_in [3];
   logic [63:0]        rlo [3];
   logic [63:0]        rhi [3];
   logic signed [31:0] pt [3];
   logic signed [63:0] prod_in [3][3];

   assign rlo[0] = cfg.xrow_lo;
   assign rhi[0] = cfg.xrow_hi;
   assign rlo[1] = cfg.yrow_lo;
   assign rhi[1] = cfg.yrow_hi;
   assign rlo[2] = cfg.wrow_lo;
   assign rhi[2] = cfg.wrow_hi;
   assign pt[0]  = req_tdata[31:0];
   assign pt[1]  = req_tdata[63:32];
   assign pt[2]  = req_tdata[95:64];

   assign en         = !v2_ff || !q_full;
   assign req_tready = en;
   assign q_push     = v2_ff && !q_full;
   assign q_data     = {(clip_ff[2] == '0), clip_ff[2], clip_ff[1], clip_ff[0]};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = $signed(rlo[r][31:0]) * pt[0];
         prod_in[r][1] = $signed(rlo[r][63:32]) * pt[1];
         prod_in[r][2] = $signed(rhi[r][31:0]) * pt[2];
      end
   end

   always_comb begin
      logic signed [63:0] acc;
      for (int r = 0; r < 3; r++) begin
         acc = 64'(cst_ff[r]) + (prod_ff[r][0] >>> FRAC_BITS)
             + (prod_ff[r][1] >>> FRAC_BITS) + (prod_ff[r][2] >>> FRAC_BITS);
         clip_in[r] = acc[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            cst_ff[r]  <= $signed(rhi[r][63:32]);
            clip_ff[r] <= clip_in[r];
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= prod_in[r][c];
            end
         end
      end
   end

endmodule

>>> hdl/ppv_fifo.sv
// Short queue between the front and back ends.
`timescale 1ns / 1ps
module ppv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       wdata,
   input  logic                   pop,
   output logic [WIDTH-1:0]       rdata,
   output ppv_pkg::fifo_stat_type stat
);
   import ppv_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wp_ff, rp_ff;
   logic [NW-1:0]    cnt_ff;

   assign stat.full  = (cnt_ff == NW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign rdata      = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + NW'(push) - NW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

endmodule

>>> hdl/ppv_back.sv
// Back end: viewport mapping, pipelined floored division and saturation.
`timescale 1ns / 1ps
module ppv_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ppv_pkg::cfg_type           cfg,
   input  logic [3*(66-FRAC_BITS):0]  q_data,
   input  logic                       q_empty,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,
   output logic [1:0]                 rsp_tuser
);
   import ppv_pkg::*;

   localparam int CW = 66 - FRAC_BITS;
   localparam int SW = CW + 1;
   localparam int HW = SW - 32;
   localparam int NW = 33 + SW;
   localparam int QB = QUO_BITS;
   localparam int VW = QB + 2;

   typedef struct packed {
      logic [32:0]        sm;
      logic [SW-1:0]      um;
      logic [SW-1:0]      d;
      logic               neg;
      logic signed [31:0] lo;
   } p0_type;

   typedef struct packed {
      logic [64:0]        pl;
      logic [32+HW:0]     ph;
      logic [SW-1:0]      d;
      logic               neg;
      logic signed [31:0] lo;
   } p1_type;

   typedef struct packed {
      logic [NW-1:0]      n;
      logic [SW-1:0]      d;
      logic               neg;
      logic signed [31:0] lo;
   } p2_type;

   typedef struct packed {
      logic [SW-1:0]      r;
      logic [QB-1:0]      nl;
      logic [QB-1:0]      q;
      logic [SW-1:0]      d;
      logic               neg;
      logic               sat;
      logic signed [31:0] lo;
   } dv_type;

   function automatic dv_type div_step(input dv_type s);
      dv_type       o;
      logic [SW:0]  rr;
      logic [SW:0]  df;
      logic         ge;
      o  = s;
      rr = {s.r, s.nl[QB-1]};
      ge = (rr >= {1'b0, s.d});
      df = rr - {1'b0, s.d};
      o.r  = ge ? df[SW-1:0] : rr[SW-1:0];
      o.q  = {s.q[QB-2:0], ge};
      o.nl = {s.nl[QB-2:0], 1'b0};
      return o;
   endfunction

   logic              en;
   logic [CW-1:0]     cx, cy, cw;
   logic              wz;
   logic              vp0_ff, vp1_ff, vp2_ff;
   logic              wp0_ff, wp1_ff, wp2_ff;
   logic              vd_ff [QB+1];
   logic              wd_ff [QB+1];
   p0_type            p0_ff [2];
   p0_type            p0_in [2];
   p1_type            p1_ff [2];
   p2_type            p2_ff [2];
   dv_type            dv_ff [2][QB+1];
   dv_type            d0_in [2];
   logic signed [31:0] scr_in [2];
   logic              sat_in [2];
   logic              tvalid_ff;
   logic [63:0]       tdata_ff;
   logic [1:0]        tuser_ff;

   assign cx = q_data[CW-1:0];
   assign cy = q_data[2*CW-1:CW];
   assign cw = q_data[3*CW-1:2*CW];
   assign wz = q_data[3*CW];

   assign en         = !tvalid_ff || rsp_tready;
   assign q_pop      = en && !q_empty;
   assign rsp_tvalid = tvalid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tuser  = tuser_ff;

   always_comb begin
      logic [CW-1:0]      clip;
      logic signed [31:0] elo, ehi;
      logic [32:0]        span;
      logic [SW-1:0]      sum, den;
      for (int a = 0; a < 2; a++) begin
         clip = (a == 0) ? cx : cy;
         elo  = (a == 0) ? cfg.viewport_horiz[31:0] : cfg.viewport_vert[31:0];
         ehi  = (a == 0) ? cfg.viewport_horiz[63:32] : cfg.viewport_vert[63:32];
         span = {ehi[31], ehi} - {elo[31], elo};
         sum  = {clip[CW-1], clip} + {cw[CW-1], cw};
         den  = {cw, 1'b0};
         p0_in[a].sm  = span[32] ? -span : span;
         p0_in[a].um  = sum[SW-1] ? -sum : sum;
         p0_in[a].d   = den[SW-1] ? -den : den;
         p0_in[a].neg = span[32] ^ sum[SW-1] ^ den[SW-1];
         p0_in[a].lo  = elo;
      end
   end

   always_comb begin
      logic [NW-QB-1:0] r0;
      for (int a = 0; a < 2; a++) begin
         r0 = p2_ff[a].n[NW-1:QB];
         d0_in[a].r   = SW'(r0);
         d0_in[a].nl  = p2_ff[a].n[QB-1:0];
         d0_in[a].q   = '0;
         d0_in[a].d   = p2_ff[a].d;
         d0_in[a].neg = p2_ff[a].neg;
         d0_in[a].sat = (SW'(r0) >= p2_ff[a].d);
         d0_in[a].lo  = p2_ff[a].lo;
      end
   end

   always_comb begin
      dv_type             s;
      logic               sat;
      logic [VW-1:0]      mq, val;
      logic signed [VW:0] tot;
      logic [VW-31:0]     top;
      for (int a = 0; a < 2; a++) begin
         s   = dv_ff[a][QB];
         sat = s.sat || s.q[QB-1];
         mq  = VW'(s.q);
         val = s.neg ? -(mq + VW'(s.r != '0)) : mq;
         tot = $signed({val[VW-1], val}) + (VW+1)'(s.lo);
         top = tot[VW:31];
         if (sat) begin
            scr_in[a] = s.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else if (top != '0 && top != '1) begin
            sat       = 1'b1;
            scr_in[a] = tot[VW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            scr_in[a] = tot[31:0];
         end
         sat_in[a] = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp0_ff    <= 1'b0;
         vp1_ff    <= 1'b0;
         vp2_ff    <= 1'b0;
         tvalid_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) begin
            vd_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vp0_ff    <= !q_empty;
         vp1_ff    <= vp0_ff;
         vp2_ff    <= vp1_ff;
         vd_ff[0]  <= vp2_ff;
         for (int k = 1; k <= QB; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         tvalid_ff <= vd_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wp0_ff   <= wz;
         wp1_ff   <= wp0_ff;
         wp2_ff   <= wp1_ff;
         wd_ff[0] <= wp2_ff;
         for (int k = 1; k <= QB; k++) begin
            wd_ff[k] <= wd_ff[k-1];
         end
         for (int a = 0; a < 2; a++) begin
            p0_ff[a]    <= p0_in[a];
            p1_ff[a].pl <= p0_ff[a].sm * p0_ff[a].um[31:0];
            p1_ff[a].ph <= p0_ff[a].sm * p0_ff[a].um[SW-1:32];
            p1_ff[a].d   <= p0_ff[a].d;
            p1_ff[a].neg <= p0_ff[a].neg;
            p1_ff[a].lo  <= p0_ff[a].lo;
            p2_ff[a].n   <= NW'(p1_ff[a].pl) + (NW'(p1_ff[a].ph) << 32);
            p2_ff[a].d   <= p1_ff[a].d;
            p2_ff[a].neg <= p1_ff[a].neg;
            p2_ff[a].lo  <= p1_ff[a].lo;
            dv_ff[a][0]  <= d0_in[a];
            for (int k = 1; k <= QB; k++) begin
               dv_ff[a][k] <= div_step(dv_ff[a][k-1]);
            end
         end
         if (wd_ff[QB]) begin
            tdata_ff <= '0;
            tuser_ff <= 2'b01;
         end else begin
            tdata_ff <= {scr_in[1], scr_in[0]};
            tuser_ff <= {sat_in[0] || sat_in[1], 1'b0};
         end
      end
   end

endmodule
